@@ design/multi_arena_bump_allocator_core_defines.svh @@
// Assertion helpers shared by the allocator core.
`ifndef MULTI_ARENA_BUMP_ALLOCATOR_CORE_DEFINES_SVH
`define MULTI_ARENA_BUMP_ALLOCATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MAB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MAB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/mab_pkg.sv @@
package mab_pkg;

    localparam int MAX_ARENAS_DEF          = 8;
    localparam int PAGE_BYTES_DEF          = 4096;
    localparam int DEFAULT_ARENA_BYTES_DEF = 65536;

    localparam int SIZE_W  = 32;
    localparam int TOTAL_W = 36;
    localparam int IDX_W   = 3;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_REPORT = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CFG_MAX_ARENAS  = 2'd0,
        CFG_NEW_SIZE    = 2'd1,
        CFG_START_SIZE  = 2'd2,
        CFG_KEEP_CHAIN  = 2'd3
    } cfg_idx_t;

    // Operation selected on the shared step unit.
    typedef enum logic [1:0] {
        MODE_FIT   = 2'd0,
        MODE_ACC   = 2'd1,
        MODE_QUOT  = 2'd2,
        MODE_ALIGN = 2'd3
    } step_mode_t;

endpackage

@@ design/mab_ram.sv @@
module mab_ram
    #(
        parameter int WIDTH = 32,
        parameter int DEPTH = 8
    )
    (
        input  logic                                    clk,
        input  logic                                    we,
        input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
        input  logic [WIDTH-1:0]                        wdata,
        input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
        output logic [WIDTH-1:0]                        rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/mab_step.sv @@
module mab_step
    import mab_pkg::*;
    #(
        parameter int PAGE_BYTES = PAGE_BYTES_DEF
    )
    (
        input  step_mode_t                     mode,
        input  logic [SIZE_W-1:0]              a,
        input  logic [SIZE_W-1:0]              b,
        input  logic [SIZE_W-1:0]              c,
        input  logic [TOTAL_W-1:0]             used_acc,
        input  logic [TOTAL_W-1:0]             free_acc,
        input  logic [SIZE_W-1:0]              quot_in,
        output logic [SIZE_W-1:0]              sum,
        output logic                           fit,
        output logic [TOTAL_W-1:0]             used_nxt,
        output logic [TOTAL_W-1:0]             free_nxt,
        output logic [SIZE_W-1:0]              quot_nxt,
        output logic [SIZE_W-1:0]              aligned
    );

    // Scaled reciprocal of the page size. The top bits of the product with any
    // 32-bit dividend give the exact quotient.
    localparam int LG = $clog2(PAGE_BYTES);
    localparam int QW = 2 * SIZE_W + 1;
    localparam int PW = $clog2(PAGE_BYTES + 1);
    localparam int AW = SIZE_W + 1 + PW;
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << (SIZE_W + LG)) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
    localparam logic [SIZE_W:0] RECIP = (SIZE_W+1)'(RECIP_VAL);
    localparam longint unsigned CLAMP = (64'hFFFF_FFFF / PAGE_BYTES) * PAGE_BYTES;
    localparam logic [SIZE_W-1:0] CLAMP32 = SIZE_W'(CLAMP);

    logic [SIZE_W:0]    fit_sum;
    logic [TOTAL_W:0]   used_sum;
    logic [TOTAL_W:0]   free_sum;
    logic [SIZE_W-1:0]  room;
    logic [QW-1:0]      quot_prod;
    logic [AW-1:0]      round_prod;

    always_comb
    begin
        sum        = '0;
        fit        = 1'b0;
        used_nxt   = used_acc;
        free_nxt   = free_acc;
        quot_nxt   = quot_in;
        aligned    = '0;
        fit_sum    = '0;
        used_sum   = '0;
        free_sum   = '0;
        room       = '0;
        quot_prod  = '0;
        round_prod = '0;
        unique case (mode)
            MODE_FIT:
            begin
                fit_sum = {1'b0, a} + {1'b0, b};
                sum     = fit_sum[SIZE_W-1:0];
                fit     = fit_sum <= {1'b0, c};
            end
            MODE_ACC:
            begin
                // An arena filled past its capacity adds nothing to the free total.
                room     = (c > a) ? (c - a) : '0;
                used_sum = (TOTAL_W+1)'(used_acc) + (TOTAL_W+1)'(a);
                free_sum = (TOTAL_W+1)'(free_acc) + (TOTAL_W+1)'(room);
                used_nxt = used_sum[TOTAL_W] ? '1 : used_sum[TOTAL_W-1:0];
                free_nxt = free_sum[TOTAL_W] ? '1 : free_sum[TOTAL_W-1:0];
            end
            MODE_QUOT:
            begin
                // Quotient of (size - 1) by the page size; the size is never zero,
                // so one more than this quotient counts the pages that cover it.
                quot_prod = QW'(a - SIZE_W'(1)) * QW'(RECIP);
                quot_nxt  = SIZE_W'(quot_prod >> (SIZE_W + LG));
            end
            MODE_ALIGN:
            begin
                round_prod = (AW'(quot_in) + AW'(1)) * AW'(PAGE_BYTES);
                aligned    = (round_prod > AW'(64'hFFFF_FFFF)) ?
                             CLAMP32 : round_prod[SIZE_W-1:0];
            end
            default:
            begin
                sum = '0;
            end
        endcase
    end

endmodule

@@ design/multi_arena_bump_allocator_core.sv @@
// Channel   Dir  Payload (lowest bit first)
// s_axis    in   op[1:0], request_size[33:2], zero pad to 40 bits
// m_axis    out  granted[0], arena_index[3:1], block_offset[35:4],
//                used_total[71:36], free_total[107:72], zero pad to 112 bits
// cfg       in   cfg_we, cfg_index (register number), cfg_data (32 bits)
//
// An allocate walks the arenas first fit; the walk visits one arena per cycle
// through the registered RAM read. Opening a new arena goes through the page
// quotient, the alignment of the size and a try of the new arena, in that order.
// Report walks every arena, as does an allocate that misses them all; clear,
// zero-size allocate and unknown op go straight to the result.
// Reset is immediate: per-arena valid bits make every fill read as zero.
// A result waits in the output register while m_axis stalls; a new request is
// taken only once the block is back in idle.
`include "multi_arena_bump_allocator_core_defines.svh"

module multi_arena_bump_allocator_core
    import mab_pkg::*;
    #(
        parameter int MAX_ARENAS          = MAX_ARENAS_DEF,
        parameter int PAGE_BYTES          = PAGE_BYTES_DEF,
        parameter int DEFAULT_ARENA_BYTES = DEFAULT_ARENA_BYTES_DEF
    )
    (
        input  logic         clk,
        input  logic         rst_n,
        input  logic         s_axis_tvalid,
        output logic         s_axis_tready,
        input  logic [39:0]  s_axis_tdata,   // op, request_size
        output logic         m_axis_tvalid,
        input  logic         m_axis_tready,
        output logic [111:0] m_axis_tdata,   // granted, arena_index, block_offset,
                                             // used_total, free_total
        input  logic         cfg_we,
        input  logic [1:0]   cfg_index,
        input  logic [31:0]  cfg_data
    );

    localparam int IW        = (MAX_ARENAS > 1) ? $clog2(MAX_ARENAS) : 1;
    localparam int CW        = $clog2(MAX_ARENAS + 1);
    localparam int DEPTH     = 1 << IW;
    localparam logic [SIZE_W-1:0] DEFAULT_SIZE = SIZE_W'(DEFAULT_ARENA_BYTES);

    // One-hot sequencer states.
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_WALK = 6'b000010,
        S_QUOT = 6'b000100,
        S_GROW = 6'b001000,
        S_TRY  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Configuration.
    logic [3:0]         max_arenas_reg, max_arenas_next;
    logic [SIZE_W-1:0]  new_size_reg, new_size_next;
    logic [SIZE_W-1:0]  cap0_reg, cap0_next;
    logic               keep_reg, keep_next;

    // Arena chain bookkeeping.
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [DEPTH-1:0]   valid_reg, valid_next;

    // Work registers of the current request.
    op_t                op_reg, op_next;
    logic [SIZE_W-1:0]  sz_reg, sz_next;
    logic [IW-1:0]      ev_idx_reg, ev_idx_next;
    logic [TOTAL_W-1:0] used_reg, used_next;
    logic [TOTAL_W-1:0] free_reg, free_next;
    logic [SIZE_W-1:0]  quot_reg, quot_next;
    logic [SIZE_W-1:0]  new_cap_reg, new_cap_next;

    // Finished result waiting for the output register.
    logic               res_granted_reg, res_granted_next;
    logic [IDX_W-1:0]   res_idx_reg, res_idx_next;
    logic [SIZE_W-1:0]  res_off_reg, res_off_next;
    logic [TOTAL_W-1:0] res_used_reg, res_used_next;
    logic [TOTAL_W-1:0] res_free_reg, res_free_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic               out_granted_reg, out_granted_next;
    logic [IDX_W-1:0]   out_idx_reg, out_idx_next;
    logic [SIZE_W-1:0]  out_off_reg, out_off_next;
    logic [TOTAL_W-1:0] out_used_reg, out_used_next;
    logic [TOTAL_W-1:0] out_free_reg, out_free_next;

    logic [1:0]         in_op;
    logic [SIZE_W-1:0]  in_size;
    logic [SIZE_W-1:0]  want;
    logic [IW-1:0]      rd_addr;
    logic [SIZE_W-1:0]  fill_rd;
    logic [SIZE_W-1:0]  cap_rd;
    logic [SIZE_W-1:0]  cur_fill;
    logic [SIZE_W-1:0]  cur_cap;
    logic               is_last;
    logic               can_grow;
    logic               fill_we;
    logic               cap_we;

    step_mode_t         st_mode;
    logic [SIZE_W-1:0]  st_a;
    logic [SIZE_W-1:0]  st_b;
    logic [SIZE_W-1:0]  st_c;
    logic [SIZE_W-1:0]  st_sum;
    logic               st_fit;
    logic [TOTAL_W-1:0] st_used;
    logic [TOTAL_W-1:0] st_free;
    logic [SIZE_W-1:0]  st_quot;
    logic [SIZE_W-1:0]  st_aligned;

    assign in_op   = s_axis_tdata[1:0];
    assign in_size = s_axis_tdata[33:2];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_free_reg, out_used_reg, out_off_reg,
                            out_idx_reg, out_granted_reg};

    // Size of an added arena before page rounding.
    assign want = (new_size_reg == '0) ? DEFAULT_SIZE : new_size_reg;

    // The walk reads one arena ahead so that each cycle evaluates a new arena.
    assign rd_addr = (state_reg == S_IDLE) ? '0 : ev_idx_reg + IW'(1);

    // Arena 0's capacity lives in a register since configuration rewrites it
    // directly. A fill whose valid bit is clear reads as zero (reset, clear, or a missed new arena).
    assign cur_cap  = (ev_idx_reg == '0) ? cap0_reg : cap_rd;
    assign cur_fill = valid_reg[ev_idx_reg] ? fill_rd : '0;

    assign is_last  = (CW'(ev_idx_reg) + CW'(1)) == cnt_reg;
    assign can_grow = (32'(cnt_reg) < 32'(max_arenas_reg)) &&
                      (cnt_reg < CW'(MAX_ARENAS));

    mab_ram
        #(
            .WIDTH (SIZE_W),
            .DEPTH (DEPTH)
        )
        u_fill_ram
        (
            .clk   (clk),
            .we    (fill_we),
            .waddr (ev_idx_reg),
            .wdata (st_sum),
            .raddr (rd_addr),
            .rdata (fill_rd)
        );

    mab_ram
        #(
            .WIDTH (SIZE_W),
            .DEPTH (DEPTH)
        )
        u_cap_ram
        (
            .clk   (clk),
            .we    (cap_we),
            .waddr (ev_idx_reg),
            .wdata (new_cap_reg),
            .raddr (rd_addr),
            .rdata (cap_rd)
        );

    mab_step
        #(
            .PAGE_BYTES (PAGE_BYTES)
        )
        u_step
        (
            .mode     (st_mode),
            .a        (st_a),
            .b        (st_b),
            .c        (st_c),
            .used_acc (used_reg),
            .free_acc (free_reg),
            .quot_in  (quot_reg),
            .sum      (st_sum),
            .fit      (st_fit),
            .used_nxt (st_used),
            .free_nxt (st_free),
            .quot_nxt (st_quot),
            .aligned  (st_aligned)
        );

    always_comb
    begin
        state_next       = state_reg;
        max_arenas_next  = max_arenas_reg;
        new_size_next    = new_size_reg;
        cap0_next        = cap0_reg;
        keep_next        = keep_reg;
        cnt_next         = cnt_reg;
        valid_next       = valid_reg;
        op_next          = op_reg;
        sz_next          = sz_reg;
        ev_idx_next      = ev_idx_reg;
        used_next        = used_reg;
        free_next        = free_reg;
        quot_next        = quot_reg;
        new_cap_next     = new_cap_reg;
        res_granted_next = res_granted_reg;
        res_idx_next     = res_idx_reg;
        res_off_next     = res_off_reg;
        res_used_next    = res_used_reg;
        res_free_next    = res_free_reg;
        out_valid_next   = out_valid_reg;
        out_granted_next = out_granted_reg;
        out_idx_next     = out_idx_reg;
        out_off_next     = out_off_reg;
        out_used_next    = out_used_reg;
        out_free_next    = out_free_reg;
        fill_we          = 1'b0;
        cap_we           = 1'b0;
        st_mode          = MODE_FIT;
        st_a             = '0;
        st_b             = sz_reg;
        st_c             = '0;

        // Configuration writes must arrive only while the block is idle; the block does not enforce this.
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MAX_ARENAS: max_arenas_next = cfg_data[3:0];
                CFG_NEW_SIZE:   new_size_next   = cfg_data;
                CFG_START_SIZE: cap0_next = (cfg_data == '0) ? DEFAULT_SIZE : cfg_data;
                CFG_KEEP_CHAIN: keep_next = cfg_data[0];
                default:        keep_next = keep_reg;
            endcase
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next          = op_t'(in_op);
                    sz_next          = in_size;
                    ev_idx_next      = '0;
                    used_next        = '0;
                    free_next        = '0;
                    res_granted_next = 1'b0;
                    res_idx_next     = '0;
                    res_off_next     = '0;
                    res_used_next    = '0;
                    res_free_next    = '0;
                    unique case (in_op)
                        OP_ALLOC:
                        begin
                            // A zero-size request fails at once and opens nothing.
                            state_next = (in_size != '0) ? S_WALK : S_DONE;
                        end
                        OP_CLEAR:
                        begin
                            valid_next       = '0;
                            res_granted_next = 1'b1;
                            if (!keep_reg)
                            begin
                                cnt_next = CW'(1);
                            end
                            state_next = S_DONE;
                        end
                        OP_REPORT:
                        begin
                            state_next = S_WALK;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                st_a = cur_fill;
                st_c = cur_cap;
                if (op_reg == OP_REPORT)
                begin
                    st_mode   = MODE_ACC;
                    used_next = st_used;
                    free_next = st_free;
                    if (is_last)
                    begin
                        res_granted_next = 1'b1;
                        res_used_next    = st_used;
                        res_free_next    = st_free;
                        state_next       = S_DONE;
                    end
                    else
                    begin
                        ev_idx_next = ev_idx_reg + IW'(1);
                    end
                end
                else
                begin
                    st_mode = MODE_FIT;
                    if (st_fit)
                    begin
                        fill_we                = 1'b1;
                        valid_next[ev_idx_reg] = 1'b1;
                        res_granted_next       = 1'b1;
                        res_idx_next           = IDX_W'(ev_idx_reg);
                        res_off_next           = cur_fill;
                        state_next             = S_DONE;
                    end
                    else if (!is_last)
                    begin
                        ev_idx_next = ev_idx_reg + IW'(1);
                    end
                    else if (can_grow)
                    begin
                        state_next = S_QUOT;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_QUOT:
            begin
                // Page quotient of the wanted size minus one, by reciprocal multiplication.
                st_mode   = MODE_QUOT;
                st_a      = want;
                quot_next = st_quot;
                state_next = S_GROW;
            end

            S_GROW:
            begin
                st_mode      = MODE_ALIGN;
                new_cap_next = st_aligned;
                ev_idx_next  = IW'(cnt_reg);
                state_next   = S_TRY;
            end

            S_TRY:
            begin
                // The new arena stays counted even when the request misses it.
                st_mode  = MODE_FIT;
                st_a     = '0;
                st_c     = new_cap_reg;
                cap_we   = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                if (st_fit)
                begin
                    fill_we                = 1'b1;
                    valid_next[ev_idx_reg] = 1'b1;
                    res_granted_next       = 1'b1;
                    res_idx_next           = IDX_W'(ev_idx_reg);
                    res_off_next           = '0;
                end
                else
                begin
                    valid_next[ev_idx_reg] = 1'b0;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_granted_next = res_granted_reg;
                    out_idx_next     = res_idx_reg;
                    out_off_next     = res_off_reg;
                    out_used_next    = res_used_reg;
                    out_free_next    = res_free_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            max_arenas_reg <= '0;
            new_size_reg   <= '0;
            cap0_reg       <= DEFAULT_SIZE;
            keep_reg       <= 1'b0;
            cnt_reg        <= CW'(1);
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            max_arenas_reg <= max_arenas_next;
            new_size_reg   <= new_size_next;
            cap0_reg       <= cap0_next;
            keep_reg       <= keep_next;
            cnt_reg        <= cnt_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        sz_reg          <= sz_next;
        ev_idx_reg      <= ev_idx_next;
        used_reg        <= used_next;
        free_reg        <= free_next;
        quot_reg        <= quot_next;
        new_cap_reg     <= new_cap_next;
        res_granted_reg <= res_granted_next;
        res_idx_reg     <= res_idx_next;
        res_off_reg     <= res_off_next;
        res_used_reg    <= res_used_next;
        res_free_reg    <= res_free_next;
        out_granted_reg <= out_granted_next;
        out_idx_reg     <= out_idx_next;
        out_off_reg     <= out_off_next;
        out_used_reg    <= out_used_next;
        out_free_reg    <= out_free_next;
    end

    // The chain always holds at least the start arena and never exceeds MAX_ARENAS.
    `MAB_ASSERT_SAME(a_count_range, 1'b1, (cnt_reg != '0) && (cnt_reg <= CW'(MAX_ARENAS)), "arena count out of range")
    // A fill update always finishes the request.
    `MAB_ASSERT_NEXT(a_fill_ends_request, fill_we, state_reg == S_DONE, "fill written but request still running")
    // Trying a new arena adds exactly one arena to the chain.
    `MAB_ASSERT_NEXT(a_grow_by_one, state_reg == S_TRY, cnt_reg == $past(cnt_reg) + CW'(1), "arena count did not grow by one")

endmodule

@@ tb/arena_result_checker.sv @@
`timescale 1ns / 100ps

module arena_result_checker
    import mab_pkg::*;
    (
        input  logic         clk,
        input  logic         rst_n,
        input  logic         s_axis_tvalid,
        input  logic         s_axis_tready,
        input  logic [39:0]  s_axis_tdata,   // op, request_size
        input  logic         m_axis_tvalid,
        input  logic         m_axis_tready,
        input  logic [111:0] m_axis_tdata,   // granted, arena_index, block_offset,
                                             // used_total, free_total
        input  logic         cfg_we,
        input  logic [1:0]   cfg_index,
        input  logic [31:0]  cfg_data,
        output int unsigned  mismatches,
        output int unsigned  outstanding
    );

    localparam logic [31:0] DEFAULT_BYTES = 32'(DEFAULT_ARENA_BYTES_DEF);
    localparam logic [63:0] PAGE          = 64'(PAGE_BYTES_DEF);
    localparam logic [63:0] TOTAL_MAX     = 64'h0000_000F_FFFF_FFFF;

    typedef struct packed {
        logic        granted;
        logic [2:0]  arena_index;
        logic [31:0] block_offset;
        logic [35:0] used_total;
        logic [35:0] free_total;
    } alloc_result_t;

    // Mirror of the allocator state and its register file.
    logic [31:0] arena_fill     [MAX_ARENAS_DEF];
    logic [31:0] arena_capacity [MAX_ARENAS_DEF];
    int unsigned arena_count;
    logic [3:0]  max_arenas_reg;
    logic [31:0] new_size_reg;
    logic [31:0] start_size_reg;
    logic        keep_chain_reg;

    alloc_result_t awaited_results[$];

    function automatic bit claim_space(int unsigned slot, logic [31:0] size,
                                       output logic [31:0] offset);
        offset = '0;
        if (33'(arena_fill[slot]) + 33'(size) > 33'(arena_capacity[slot]))
            return 1'b0;
        offset = arena_fill[slot];
        arena_fill[slot] = arena_fill[slot] + size;
        return 1'b1;
    endfunction

    function automatic alloc_result_t predict_allocation(logic [1:0] op, logic [31:0] size);
        alloc_result_t res;
        logic [31:0]   offset;
        logic [63:0]   want;
        logic [63:0]   rounded;
        logic [63:0]   used_sum;
        logic [63:0]   free_sum;
        bit            hit;
        int unsigned   slot;
        res = '0;
        hit = 1'b0;
        case (op)
            OP_ALLOC:
                if (size != 0) begin
                    for (int unsigned i = 0; i < arena_count && !hit; i++) begin
                        if (claim_space(i, size, offset)) begin
                            hit = 1'b1;
                            res.arena_index = 3'(i);
                        end
                    end
                    // Open one more arena and try the request there once.
                    if (!hit && arena_count < max_arenas_reg && arena_count < MAX_ARENAS_DEF) begin
                        slot    = arena_count;
                        want    = (new_size_reg == 0) ? 64'(DEFAULT_BYTES) : 64'(new_size_reg);
                        rounded = ((want + PAGE - 1) / PAGE) * PAGE;
                        if (rounded > 64'hFFFF_FFFF)
                            rounded = (64'hFFFF_FFFF / PAGE) * PAGE;
                        arena_capacity[slot] = rounded[31:0];
                        arena_fill[slot]     = '0;
                        arena_count          = slot + 1;
                        if (claim_space(slot, size, offset)) begin
                            hit = 1'b1;
                            res.arena_index = 3'(slot);
                        end
                    end
                    if (hit) begin
                        res.granted      = 1'b1;
                        res.block_offset = offset;
                    end
                    else begin
                        res.arena_index = '0;
                    end
                end
            OP_CLEAR: begin
                for (int i = 0; i < MAX_ARENAS_DEF; i++)
                    arena_fill[i] = '0;
                if (!keep_chain_reg)
                    arena_count = 1;
                res.granted = 1'b1;
            end
            OP_REPORT: begin
                used_sum = '0;
                free_sum = '0;
                for (int unsigned i = 0; i < arena_count; i++) begin
                    used_sum += 64'(arena_fill[i]);
                    if (arena_capacity[i] > arena_fill[i])
                        free_sum += 64'(arena_capacity[i] - arena_fill[i]);
                end
                res.used_total = (used_sum > TOTAL_MAX) ? TOTAL_MAX[35:0] : used_sum[35:0];
                res.free_total = (free_sum > TOTAL_MAX) ? TOTAL_MAX[35:0] : free_sum[35:0];
                res.granted    = 1'b1;
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        alloc_result_t got;
        alloc_result_t want;
        if (!rst_n) begin
            for (int i = 0; i < MAX_ARENAS_DEF; i++) begin
                arena_fill[i]     = '0;
                arena_capacity[i] = '0;
            end
            arena_capacity[0] = DEFAULT_BYTES;
            arena_count       = 1;
            max_arenas_reg    = '0;
            new_size_reg      = '0;
            start_size_reg    = '0;
            keep_chain_reg    = 1'b0;
            awaited_results.delete();
            mismatches        = 0;
            outstanding       = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MAX_ARENAS: max_arenas_reg = cfg_data[3:0];
                    CFG_NEW_SIZE:   new_size_reg   = cfg_data;
                    CFG_START_SIZE: begin
                        start_size_reg    = cfg_data;
                        arena_capacity[0] = (cfg_data == 0) ? DEFAULT_BYTES : cfg_data;
                    end
                    CFG_KEEP_CHAIN: keep_chain_reg = cfg_data[0];
                    default: ;
                endcase
            end

            // Results are checked before new requests are predicted, so the
            // queue order always matches the order of transfers.
            if (m_axis_tvalid && m_axis_tready) begin
                got.granted      = m_axis_tdata[0];
                got.arena_index  = m_axis_tdata[3:1];
                got.block_offset = m_axis_tdata[35:4];
                got.used_total   = m_axis_tdata[71:36];
                got.free_total   = m_axis_tdata[107:72];
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: %0t result with nothing awaited: %p", $realtime, got);
                end
                else begin
                    want = awaited_results.pop_front();
                    if (got.granted !== want.granted || got.arena_index !== want.arena_index
                        || got.block_offset !== want.block_offset
                        || got.used_total !== want.used_total
                        || got.free_total !== want.free_total) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: %0t result differs\n  expected %p\n  actual   %p",
                                     $realtime, want, got);
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                awaited_results.push_back(predict_allocation(s_axis_tdata[1:0],
                                                             s_axis_tdata[33:2]));
            outstanding = awaited_results.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import mab_pkg::*;

    // The op field is two bits wide; the code left over from the package
    // enum is an unknown op, which the block must answer with all zeros.
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;

    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata = '0;    // op[1:0], request_size[33:2], zero pad

    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;         // granted[0], arena_index[3:1],
                                        // block_offset[35:4], used_total[71:36],
                                        // free_total[107:72], zero pad

    logic         cfg_we = 1'b0;
    cfg_idx_t     cfg_index = CFG_MAX_ARENAS;
    logic [31:0]  cfg_data = '0;

    int unsigned  mismatches;
    int unsigned  outstanding;

    // When set, both the request side and the result side run without gaps.
    bit           no_idle = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    multi_arena_bump_allocator_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    arena_result_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // One register write lasts exactly one clock; the enable drops on the
    // following edge, so back-to-back calls leave the enable low between writes.
    task automatic write_register(cfg_idx_t index, logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic apply_settings(logic [3:0] max_count, logic [31:0] grow_bytes,
                                  logic [31:0] first_bytes, logic keep_chain);
        write_register(CFG_MAX_ARENAS, 32'(max_count));
        write_register(CFG_NEW_SIZE, grow_bytes);
        write_register(CFG_START_SIZE, first_bytes);
        write_register(CFG_KEEP_CHAIN, 32'(keep_chain));
    endtask

    // Waits until every predicted result has been taken from the block, then
    // lets the longest walk (eight arenas plus the growth path) run out, so
    // that the block is certainly idle before registers change.
    task automatic drain_block();
        @(posedge clk);
        wait (outstanding == 0);
        repeat (24) @(posedge clk);
    endtask

    // One request transfer. The sender idles for a random number of cycles
    // first, then holds tvalid until the block takes the request.
    task automatic send_request(logic [1:0] op, logic [31:0] size);
        repeat (no_idle ? 0 : $urandom_range(0, 18)) @(posedge clk);
        @(posedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, size, op};
        do @(posedge clk); while (!s_axis_tready);
        s_axis_tvalid <= 1'b0;
    endtask

    // Result side: stalls a random number of cycles before each transfer.
    // A zero stall keeps tready high across back-to-back results.
    initial
    begin : result_sink
        int unsigned stall;
        wait (rst_n);
        @(posedge clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 18);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    initial
    begin : stimulus
        logic [1:0]  op;
        logic [31:0] size;
        logic [3:0]  max_count;
        logic [31:0] grow_bytes;
        logic [31:0] first_bytes;
        int unsigned pick;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: no growth allowed, arena 0 has the default size.
        // Covers zero-size requests, an exact fill, a request that cannot
        // fit anywhere, and the unknown op with every size bit set.
        send_request(OP_REPORT, 32'd0);
        send_request(OP_ALLOC, 32'd0);
        send_request(OP_ALLOC, 32'd1);
        send_request(OP_ALLOC, 32'hFFFF_FFFF);
        send_request(OP_ALLOC, 32'd65535);
        send_request(OP_ALLOC, 32'd1);
        send_request(OP_UNKNOWN, 32'hFFFF_FFFF);
        send_request(OP_REPORT, 32'hFFFF_FFFF);
        send_request(OP_CLEAR, 32'd0);

        // A one-byte first arena and an added size that would round past
        // 32 bits, so new arenas get the largest page multiple. The chain
        // survives a clear. The all-ones request opens an arena it cannot
        // use, which must still be counted.
        drain_block();
        apply_settings(4'd8, 32'hFFFF_FFFF, 32'd1, 1'b1);
        send_request(OP_ALLOC, 32'd1);
        send_request(OP_ALLOC, 32'hFFFF_F000);
        send_request(OP_ALLOC, 32'hFFFF_FFFF);
        send_request(OP_REPORT, 32'd0);
        send_request(OP_CLEAR, 32'd0);
        send_request(OP_REPORT, 32'd0);

        // Limit lowered below the current count: nothing is removed, but no
        // further arena may open. The large fills push the totals high.
        drain_block();
        apply_settings(4'd2, 32'd5000, 32'hFFFF_FFFF, 1'b0);
        send_request(OP_ALLOC, 32'hFFFF_FFFF);
        send_request(OP_ALLOC, 32'd1);
        send_request(OP_ALLOC, 32'hFFFF_FFFF);
        send_request(OP_REPORT, 32'd0);

        // Arena 0 shrunk below its fill must add nothing to the free total.
        // The widest limit value lets growth resume with the default size.
        drain_block();
        apply_settings(4'd15, 32'd0, 32'd100, 1'b0);
        send_request(OP_REPORT, 32'd0);
        send_request(OP_ALLOC, 32'hFFFF_F000);
        send_request(OP_ALLOC, 32'd70000);
        send_request(OP_CLEAR, 32'd0);
        send_request(OP_REPORT, 32'd0);

        // Random phases. Each one starts from an idle block with fresh
        // settings; small arena sizes dominate so the chain fills up and
        // grows to its full length, while the rare full-range values keep
        // every size bit toggling.
        for (int phase = 0; phase < 11; phase++) begin
            drain_block();
            no_idle = (phase % 4 == 3);
            case ($urandom_range(0, 3))
                0:       max_count = 4'd0;
                1:       max_count = 4'd15;
                2:       max_count = 4'd8;
                default: max_count = 4'($urandom_range(1, 15));
            endcase
            case ($urandom_range(0, 5))
                0:       grow_bytes = 32'd0;
                1:       grow_bytes = $urandom;
                2:       grow_bytes = 32'hFFFF_FFFF;
                default: grow_bytes = $urandom_range(1, 40000);
            endcase
            case ($urandom_range(0, 5))
                0:       first_bytes = 32'd0;
                1:       first_bytes = $urandom;
                2:       first_bytes = 32'hFFFF_FFFF;
                default: first_bytes = $urandom_range(1, 30000);
            endcase
            apply_settings(max_count, grow_bytes, first_bytes, 1'($urandom_range(0, 1)));

            for (int n = 0; n < 100; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 77)
                    op = OP_ALLOC;
                else if (pick < 92)
                    op = OP_REPORT;
                else if (pick < 97)
                    op = OP_CLEAR;
                else
                    op = OP_UNKNOWN;
                case ($urandom_range(0, 9))
                    0:       size = 32'd0;
                    1:       size = $urandom;
                    2:       size = 32'hFFFF_FFFF - $urandom_range(0, 4096);
                    3, 4:    size = $urandom_range(4096, 20000);
                    default: size = $urandom_range(1, 3000);
                endcase
                send_request(op, size);
            end
        end

        drain_block();
        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Far beyond the slowest legal run, in which every request meets the
    // longest gaps on both sides and the full growth path.
    initial
    begin : watchdog
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
